FILE: src/dual_lane_fnv_hash_with_finalizer_macros.svh
// Assertion macros for the dual-lane FNV hasher.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef DUAL_LANE_FNV_HASH_WITH_FINALIZER_MACROS_SVH
`define DUAL_LANE_FNV_HASH_WITH_FINALIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLFH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DLFH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dlfh_pkg.sv
// Shared types, constants and helper functions for the dual-lane FNV hasher.
// No dependencies; used by the controller, the datapath and the top level.
package dlfh_pkg;

  localparam logic [63:0] FNV_BASIS  = 64'hcbf29ce484222325;
  localparam logic [63:0] LANE_B_ADD = 64'h000000000000009d;
  localparam logic [63:0] SALT_A     = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SALT_B     = 64'hc2b2ae3d27d4eb4f;
  localparam logic [63:0] MIX_A_MUL0 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_A_MUL1 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] MIX_B_MUL0 = 64'h7fb5d329728ea185;
  localparam logic [63:0] MIX_B_MUL1 = 64'h81dadef4bc2dd44d;

  localparam int unsigned MIX_A_SH   = 33;
  localparam int unsigned MIX_B_SH0  = 31;
  localparam int unsigned MIX_B_SH1  = 27;
  localparam int unsigned MIX_SH_END = 33;

  typedef enum logic [0:0] {
    CFG_SEED_A = 1'b0,
    CFG_SEED_B = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    MIX_PLAIN_A = 2'd0,
    MIX_SALT_A  = 2'd1,
    MIX_SALT_B  = 2'd2
  } mix_sel_t;

  typedef enum logic [1:0] {
    MP_NONE = 2'd0,
    MP_LL   = 2'd1,
    MP_HL   = 2'd2,
    MP_LH   = 2'd3
  } mul_phase_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_MUL0 = 7'b0000100,
    ST_MUL1 = 7'b0001000,
    ST_MUL2 = 7'b0010000,
    ST_XS   = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    mul_phase_t mul;
    logic       xs;
    logic       second;
    mix_sel_t   mix_sel;
    logic       emit;
  } dp_cmd_t;

  // Multiply by the FNV-64 prime 2^40 + 0x1b3 as a sum of shifted copies.
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    fnv_mul = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

  function automatic logic [63:0] mix_mul_const(input logic kind_b, input logic second);
    if (kind_b) begin
      mix_mul_const = second ? MIX_B_MUL1 : MIX_B_MUL0;
    end else begin
      mix_mul_const = second ? MIX_A_MUL1 : MIX_A_MUL0;
    end
  endfunction

endpackage

FILE: src/dlfh_in_if.sv
// Input request channel of the dual-lane FNV hasher: one byte step per request.
// No dependencies.
interface dlfh_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] data_byte;
  logic       finish;

  modport source (output valid, output has_byte, output data_byte, output finish,
                  input ready);
  modport sink (input valid, input has_byte, input data_byte, input finish,
                output ready);
endinterface

FILE: src/dlfh_out_if.sv
// Output request channel of the dual-lane FNV hasher: one digest set per request.
// No dependencies.
interface dlfh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest64;
  logic [63:0] digest128_high;
  logic [63:0] digest128_low;
  logic [63:0] byte_count;

  modport source (output valid, output digest64, output digest128_high,
                  output digest128_low, output byte_count, input ready);
  modport sink (input valid, input digest64, input digest128_high,
                input digest128_low, input byte_count, output ready);
endinterface

FILE: src/dlfh_ctrl.sv
// Controller of the dual-lane FNV hasher: request handshakes and finalizer sequencing.
// Depends on dlfh_pkg for the state encoding and the datapath command struct.
module dlfh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_finish,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output dlfh_pkg::dp_cmd_t cmd
);

  dlfh_pkg::state_t   state, state_next;
  dlfh_pkg::mix_sel_t mix_sel, mix_sel_next;
  logic               second, second_next;
  logic               out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dlfh_pkg::ST_IDLE;
      mix_sel   <= dlfh_pkg::MIX_PLAIN_A;
      second    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mix_sel   <= mix_sel_next;
      second    <= second_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    mix_sel_next = mix_sel;
    second_next  = second;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mix_sel  = mix_sel;
    cmd.second   = second;
    case (state)
      dlfh_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_finish) begin
          state_next   = dlfh_pkg::ST_LOAD;
          mix_sel_next = dlfh_pkg::MIX_PLAIN_A;
          second_next  = 1'b0;
        end
      end
      dlfh_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = dlfh_pkg::ST_MUL0;
      end
      dlfh_pkg::ST_MUL0: begin
        cmd.mul    = dlfh_pkg::MP_LL;
        state_next = dlfh_pkg::ST_MUL1;
      end
      dlfh_pkg::ST_MUL1: begin
        cmd.mul    = dlfh_pkg::MP_HL;
        state_next = dlfh_pkg::ST_MUL2;
      end
      dlfh_pkg::ST_MUL2: begin
        cmd.mul    = dlfh_pkg::MP_LH;
        state_next = dlfh_pkg::ST_XS;
      end
      dlfh_pkg::ST_XS: begin
        cmd.xs = 1'b1;
        if (!second) begin
          second_next = 1'b1;
          state_next  = dlfh_pkg::ST_MUL0;
        end else if (mix_sel == dlfh_pkg::MIX_SALT_B) begin
          state_next = dlfh_pkg::ST_DONE;
        end else begin
          second_next = 1'b0;
          state_next  = dlfh_pkg::ST_LOAD;
          if (mix_sel == dlfh_pkg::MIX_PLAIN_A) begin
            mix_sel_next = dlfh_pkg::MIX_SALT_A;
          end else begin
            mix_sel_next = dlfh_pkg::MIX_SALT_B;
          end
        end
      end
      dlfh_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = dlfh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dlfh_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

FILE: src/dlfh_datapath.sv
// Datapath of the dual-lane FNV hasher: seeds, lanes, byte count, finalizer unit
// with a shared 32x32 multiplier, and the output register. Depends on dlfh_pkg.
module dlfh_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              has_byte,
  input  logic [7:0]        data_byte,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  dlfh_pkg::dp_cmd_t cmd,
  output logic [63:0]       digest64,
  output logic [63:0]       digest128_high,
  output logic [63:0]       digest128_low,
  output logic [63:0]       byte_count
);

  logic [63:0] seed_a, seed_b;
  logic [63:0] lane_a, lane_b;
  logic [63:0] count;
  logic [63:0] h, acc;
  logic [63:0] res_64, res_hi, res_lo;

  logic [63:0] lane_a_next, lane_b_next;
  logic [63:0] mix_in, load_val, xs_val, mul_k;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        kind_b;

  assign lane_a_next = dlfh_pkg::fnv_mul(lane_a ^ {56'b0, data_byte});
  assign lane_b_next = dlfh_pkg::fnv_mul(lane_b ^ ({56'b0, data_byte} + dlfh_pkg::LANE_B_ADD));

  assign kind_b = (cmd.mix_sel == dlfh_pkg::MIX_SALT_B);

  always_comb begin
    case (cmd.mix_sel)
      dlfh_pkg::MIX_PLAIN_A: mix_in = lane_a;
      dlfh_pkg::MIX_SALT_A:  mix_in = lane_a ^ (count + dlfh_pkg::SALT_A);
      dlfh_pkg::MIX_SALT_B:  mix_in = lane_b ^ (count + dlfh_pkg::SALT_B);
      default:               mix_in = lane_a;
    endcase
  end

  assign load_val = kind_b ? (mix_in ^ (mix_in >> dlfh_pkg::MIX_B_SH0))
                           : (mix_in ^ (mix_in >> dlfh_pkg::MIX_A_SH));

  always_comb begin
    if (cmd.second) begin
      xs_val = acc ^ (acc >> dlfh_pkg::MIX_SH_END);
    end else if (kind_b) begin
      xs_val = acc ^ (acc >> dlfh_pkg::MIX_B_SH1);
    end else begin
      xs_val = acc ^ (acc >> dlfh_pkg::MIX_A_SH);
    end
  end

  // The 64-bit product modulo 2^64 is built from three 32x32 partial products.
  assign mul_k = dlfh_pkg::mix_mul_const(kind_b, cmd.second);
  assign mul_a = (cmd.mul == dlfh_pkg::MP_HL) ? h[63:32] : h[31:0];
  assign mul_b = (cmd.mul == dlfh_pkg::MP_LH) ? mul_k[63:32] : mul_k[31:0];
  assign prod  = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_a <= dlfh_pkg::FNV_BASIS;
      seed_b <= dlfh_pkg::FNV_BASIS;
      lane_a <= dlfh_pkg::FNV_BASIS;
      lane_b <= dlfh_pkg::FNV_BASIS;
      count  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dlfh_pkg::CFG_SEED_A: seed_a <= cfg_data;
          dlfh_pkg::CFG_SEED_B: seed_b <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept && has_byte) begin
        lane_a <= lane_a_next;
        lane_b <= lane_b_next;
        count  <= count + 64'd1;
      end
      if (cmd.emit) begin
        lane_a <= seed_a;
        lane_b <= seed_b;
        count  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h <= load_val;
    end
    case (cmd.mul)
      dlfh_pkg::MP_LL: acc <= prod;
      dlfh_pkg::MP_HL: acc <= acc + {prod[31:0], 32'b0};
      dlfh_pkg::MP_LH: acc <= acc + {prod[31:0], 32'b0};
      default: ;
    endcase
    if (cmd.xs) begin
      if (!cmd.second) begin
        h <= xs_val;
      end else begin
        case (cmd.mix_sel)
          dlfh_pkg::MIX_PLAIN_A: res_64 <= xs_val;
          dlfh_pkg::MIX_SALT_A:  res_hi <= xs_val;
          dlfh_pkg::MIX_SALT_B:  res_lo <= xs_val;
          default: ;
        endcase
      end
    end
    if (cmd.emit) begin
      digest64       <= res_64;
      digest128_high <= res_hi;
      digest128_low  <= res_lo;
      byte_count     <= count;
    end
  end

endmodule

FILE: src/dual_lane_fnv_hash_with_finalizer.sv
// Dual-lane FNV-1a byte hasher with fmix64 and xorshift-multiply finalizers.
// When idle, each cycle takes a request without finish; both lanes absorb its byte, if any.
// A finish request starts the finalizer: three mixes of two 64-bit multiplies each
// on one shared 32x32 multiplier (three passes per multiply).
// Synchronous reset loads both seeds and lanes with the FNV-64 offset basis and clears the count.
// Depends on dlfh_pkg, dlfh_in_if, dlfh_out_if, dlfh_ctrl, dlfh_datapath and the macro header.
`include "dual_lane_fnv_hash_with_finalizer_macros.svh"

module dual_lane_fnv_hash_with_finalizer (
  input  logic        clk,
  input  logic        rst,
  dlfh_in_if.sink     in_ch,
  dlfh_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  dlfh_pkg::dp_cmd_t cmd;
  logic              finish_take;
  logic              mul_busy;
  logic [4:0]        cmd_bits;

  assign finish_take = in_ch.valid && in_ch.ready && in_ch.finish;
  assign mul_busy    = (cmd.mul != dlfh_pkg::MP_NONE);
  assign cmd_bits    = {cmd.accept, cmd.load, mul_busy, cmd.xs, cmd.emit};

  dlfh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_finish (in_ch.finish),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  dlfh_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .has_byte       (in_ch.has_byte),
    .data_byte      (in_ch.data_byte),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .digest64       (out_ch.digest64),
    .digest128_high (out_ch.digest128_high),
    .digest128_low  (out_ch.digest128_low),
    .byte_count     (out_ch.byte_count)
  );

  `DLFH_ASSERT_NEXT(a_finish_goes_busy, finish_take, !in_ch.ready, "finish did not stall input")
  `DLFH_ASSERT_NEXT(a_emit_shows_result, cmd.emit, out_ch.valid, "emitted result not presented")
  `DLFH_ASSERT_SAME(a_single_command, 1'b1, $onehot0(cmd_bits), "datapath commands overlap")

endmodule
